// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define AST_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/mavg_pkg.sv =====
// Package with the widths, types and states of the moving average core.
`default_nettype none

package mavg_pkg;

  localparam int WINDOW_LENGTH = 50;
  localparam int SMP_W = 24;
  localparam int IDX_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int SUM_W = SMP_W + $clog2(WINDOW_LENGTH);
  localparam int DIV_W = $clog2(WINDOW_LENGTH + 1);
  localparam int CNT_W = $clog2(SUM_W + 1);

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [DIV_W-1:0] dvs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic done;
    logic neg;
    logic [SUM_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/mavg_ring.sv =====
// Sample ring memory with one write port and one registered read port.
`default_nettype none

module mavg_ring (
  input  wire                 clk,
  input  wire                 wr_en,
  input  mavg_pkg::idx_t      wr_addr,
  input  mavg_pkg::smp_t      wr_data,
  input  wire                 rd_en,
  input  mavg_pkg::idx_t      rd_addr,
  output mavg_pkg::smp_t      rd_data
);

  mavg_pkg::smp_t mem [mavg_pkg::WINDOW_LENGTH];
  mavg_pkg::smp_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/mavg_divider.sv =====
// Restoring divider of the window sum by the sample count, one quotient bit a cycle.
`default_nettype none

module mavg_divider (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  mavg_pkg::sum_t      dividend,
  input  mavg_pkg::dvs_t      divisor,
  output mavg_pkg::div_res_t  res
);

  logic                          busy_r;
  logic                          done_r;
  logic [mavg_pkg::CNT_W-1:0]    cnt_r;
  logic [mavg_pkg::SUM_W-1:0]    quot_r;
  logic [mavg_pkg::DIV_W-1:0]    rem_r;
  logic [mavg_pkg::DIV_W-1:0]    dvs_r;
  logic                          neg_r;

  logic [mavg_pkg::SUM_W-1:0]    mag;
  logic [mavg_pkg::DIV_W:0]      shifted;
  logic [mavg_pkg::DIV_W:0]      diff;
  logic                          fits;

  assign mag = dividend[mavg_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign shifted = {rem_r, quot_r[mavg_pkg::SUM_W-1]};
  assign diff = shifted - {1'b0, dvs_r};
  assign fits = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= mavg_pkg::CNT_W'(mavg_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mavg_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= mag;
      rem_r  <= '0;
      dvs_r  <= divisor;
      neg_r  <= dividend[mavg_pkg::SUM_W-1];
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits in DIV_W bits.
      rem_r  <= fits ? diff[mavg_pkg::DIV_W-1:0] : shifted[mavg_pkg::DIV_W-1:0];
      quot_r <= {quot_r[mavg_pkg::SUM_W-2:0], fits};
    end
  end

  assign res.done = done_r;
  assign res.neg  = neg_r;
  assign res.quot = quot_r;

endmodule

`default_nettype wire

// ===== rtl/moving_average_warmup_core.sv =====
// An accepted request passes through ST_SUB, ST_ADD, ST_DIV_START, the bit-serial divider in
// ST_DIV_WAIT and ST_OUT, which registers out_tvalid; only then is the next request taken.
// A finished average waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous) clears the sum, the write index, the full flag, the output
// valid flag and the sequencer; the ring keeps its contents and its data is used once it is full.
`default_nettype none

module moving_average_warmup_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // [23:0] sample
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // [23:0] average
);

  mavg_pkg::state_t    state_r, state_nxt;
  mavg_pkg::idx_t      idx_r, idx_nxt;
  logic                full_r, full_nxt;
  mavg_pkg::sum_t      sum_r, sum_nxt;
  mavg_pkg::smp_t      smp_r;
  mavg_pkg::dvs_t      dvs_r, dvs_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_data_r, out_data_nxt;

  logic                accept;
  logic                ring_wr;
  mavg_pkg::smp_t      ring_rd_data;
  logic                div_start;
  mavg_pkg::div_res_t  div_res;
  mavg_pkg::idx_t      idx_inc;
  logic                full_upd;
  logic [mavg_pkg::SUM_W-1:0] avg_full;

  assign accept = in_tvalid && in_tready;

  mavg_ring u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (idx_r),
    .wr_data (smp_r),
    .rd_en   (accept),
    .rd_addr (idx_r),
    .rd_data (ring_rd_data)
  );

  mavg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (dvs_r),
    .res      (div_res)
  );

  assign idx_inc  = (idx_r == mavg_pkg::IDX_W'(mavg_pkg::WINDOW_LENGTH - 1)) ?
                    '0 : idx_r + 1'b1;
  assign full_upd = full_r || (idx_inc == '0);
  assign avg_full = div_res.neg ? (~div_res.quot + 1'b1) : div_res.quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mavg_pkg::ST_IDLE;
      idx_r       <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      full_r      <= full_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r <= mavg_pkg::smp_t'(in_tdata);
    end
    dvs_r      <= dvs_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    full_nxt      = full_r;
    sum_nxt       = sum_r;
    dvs_nxt       = dvs_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    ring_wr       = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      mavg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = mavg_pkg::ST_SUB;
        end
      end
      mavg_pkg::ST_SUB: begin
        // The oldest sample leaves the sum only once the ring has wrapped.
        if (full_r) begin
          sum_nxt = sum_r - mavg_pkg::sum_t'(ring_rd_data);
        end
        state_nxt = mavg_pkg::ST_ADD;
      end
      mavg_pkg::ST_ADD: begin
        sum_nxt   = sum_r + mavg_pkg::sum_t'(smp_r);
        ring_wr   = 1'b1;
        idx_nxt   = idx_inc;
        full_nxt  = full_upd;
        dvs_nxt   = full_upd ? mavg_pkg::DIV_W'(mavg_pkg::WINDOW_LENGTH) :
                               mavg_pkg::DIV_W'(idx_inc);
        state_nxt = mavg_pkg::ST_DIV_START;
      end
      mavg_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = mavg_pkg::ST_DIV_WAIT;
      end
      mavg_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_nxt = mavg_pkg::ST_OUT;
        end
      end
      mavg_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = avg_full[23:0];
          state_nxt     = mavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mavg_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/mavg_checker.sv =====
// Port-level checker for the moving average core and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module mavg_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata
);

  `AST_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "stalled average was dropped")
  `AST_CLK(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled average changed")
  `AST_CLK(a_busy_after_req, in_tvalid && in_tready |=> !in_tready, "request taken while busy")
  `AST_CLK_RST(a_reset_state, !rst_n |=> !out_tvalid && in_tready, "reset did not idle the core")

endmodule

bind moving_average_warmup_core mavg_checker u_mavg_checker (.*);

`default_nettype wire

// ===== tb/moving_average_warmup_core_test.sv =====
// Self-checking testbench for the moving average core with warm-up division.
`timescale 1ns / 100ps

module moving_average_warmup_core_test;

  typedef struct {
    logic [23:0] sample;
    bit          typed;
    logic [23:0] want;
  } stim_row_t;

  typedef enum int {RUN_MIXED, RUN_HIGH, RUN_LOW, RUN_SMALL} run_kind_t;

  localparam int RANDOM_ITEMS = 1735;
  localparam int MAX_IDLE = 13;
  localparam int MAX_MISMATCH_SHOWN = 10;
  localparam logic [23:0] SMP_MAX = 24'h7FFFFF;
  localparam logic [23:0] SMP_MIN = 24'h800000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  // Running mean state as the block should hold it.
  mavg_pkg::smp_t mean_ring [mavg_pkg::WINDOW_LENGTH];
  int     mean_wr_idx;
  bit     mean_full;
  longint mean_sum;

  mavg_pkg::smp_t average_q[$];
  int   fault_count;
  bit   calm_in;
  bit   calm_out;

  // Extremes first, then sign patterns and small values where truncation matters.
  stim_row_t dir_rows [18] = '{
    '{SMP_MAX,      1'b1, SMP_MAX},
    '{SMP_MIN,      1'b1, 24'h000000},
    '{SMP_MIN,      1'b0, 24'h000000},
    '{24'h000000,   1'b0, 24'h000000},
    '{24'hFFFFFF,   1'b0, 24'h000000},
    '{24'h000001,   1'b0, 24'h000000},
    '{24'h555555,   1'b0, 24'h000000},
    '{24'hAAAAAA,   1'b0, 24'h000000},
    '{24'h000003,   1'b0, 24'h000000},
    '{24'hFFFFFD,   1'b0, 24'h000000},
    '{24'h000007,   1'b0, 24'h000000},
    '{24'hFFFFF9,   1'b0, 24'h000000},
    '{SMP_MAX,      1'b0, 24'h000000},
    '{SMP_MAX,      1'b0, 24'h000000},
    '{SMP_MIN,      1'b0, 24'h000000},
    '{24'h0F0F0F,   1'b0, 24'h000000},
    '{24'hF0F0F0,   1'b0, 24'h000000},
    '{24'h800001,   1'b0, 24'h000000}
  };

  moving_average_warmup_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic mavg_pkg::smp_t predict_average(input mavg_pkg::smp_t smp);
    longint divisor;
    if (mean_full) begin
      mean_sum -= longint'(mean_ring[mean_wr_idx]);
    end
    mean_sum += longint'(smp);
    mean_ring[mean_wr_idx] = smp;
    mean_wr_idx = (mean_wr_idx == mavg_pkg::WINDOW_LENGTH - 1) ? 0 : mean_wr_idx + 1;
    if (mean_wr_idx == 0) begin
      mean_full = 1'b1;
    end
    divisor = mean_full ? longint'(mavg_pkg::WINDOW_LENGTH) : longint'(mean_wr_idx);
    return mavg_pkg::smp_t'(mean_sum / divisor);
  endfunction

  function automatic int unsigned draw_idle(inout bit calm);
    if ($urandom_range(0, 39) == 0) begin
      calm = ~calm;
    end
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [23:0] draw_sample(input run_kind_t kind);
    logic [23:0] val;
    case (kind)
      RUN_HIGH: val = 24'(SMP_MAX - $urandom_range(0, 3));
      RUN_LOW: val = 24'(SMP_MIN + $urandom_range(0, 3));
      RUN_SMALL: val = 24'($signed($urandom_range(0, 200)) - 100);
      default: begin
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 4))
              0: val = SMP_MAX;
              1: val = SMP_MIN;
              2: val = 24'h000000;
              3: val = 24'hFFFFFF;
              default: val = 24'h000001;
            endcase
          end
          1, 2: val = 24'($signed($urandom_range(0, 2000)) - 1000);
          3: val = 24'(SMP_MAX - $urandom_range(0, 255));
          4: val = 24'(SMP_MIN + $urandom_range(0, 255));
          default: val = 24'($urandom);
        endcase
      end
    endcase
    return val;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_sample(input logic [23:0] smp, input bit typed, input logic [23:0] want);
    int unsigned    gap;
    mavg_pkg::smp_t predicted;
    gap = draw_idle(calm_in);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_average(mavg_pkg::smp_t'(smp));
    average_q.push_back(typed ? mavg_pkg::smp_t'(want) : predicted);
    @(negedge clk);
  endtask

  initial begin
    run_kind_t kind;
    int        run_left;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    mean_wr_idx = 0;
    mean_full   = 1'b0;
    mean_sum    = 0;
    fault_count = 0;
    calm_in     = 1'b0;
    kind        = RUN_MIXED;
    run_left    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
    end

    // Runs of extreme values, 30 to 90 samples long, push the sum towards its limits.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(30, 90);
        case ($urandom_range(0, 7))
          0: kind = RUN_HIGH;
          1: kind = RUN_LOW;
          2: kind = RUN_SMALL;
          default: kind = RUN_MIXED;
        endcase
      end
      run_left--;
      send_sample(draw_sample(kind), 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (average_q.size() != 0) @(posedge clk);
    repeat (mavg_pkg::SUM_W + 20) @(posedge clk);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: stalls are drawn per result and applied once a result is on offer.
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    calm_out   = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = draw_idle(calm_out);
      if (stall != 0) begin
        out_tready <= 1'b0;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    mavg_pkg::smp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (average_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_MISMATCH_SHOWN) begin
          $display("unexpected average %0d with no request outstanding", $signed(out_tdata));
        end
      end else begin
        want = average_q.pop_front();
        if (out_tdata !== want) begin
          fault_count++;
          if (fault_count <= MAX_MISMATCH_SHOWN) begin
            $display("average mismatch: expected %0d got %0d", want, $signed(out_tdata));
          end
        end
      end
    end
  end

  initial begin
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
